// ===== rtl/session_table_with_aging_defines.svh =====
// Assertion helpers shared by the session table modules.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef SESSION_TABLE_WITH_AGING_DEFINES_SVH
`define SESSION_TABLE_WITH_AGING_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sta_pkg.sv =====
`default_nettype none

package sta_pkg;

    localparam int ENTRIES      = 16;
    localparam int KEY_BYTES    = 32;
    localparam int PAYLOAD_BITS = 64;

    localparam int WORD_W    = 64;
    localparam int KEY_WORDS = 4;
    localparam int KEY_W     = WORD_W * KEY_WORDS;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int TIME_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int ACTIVE_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEANUP = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    // Bytes of the key that take part in storing and matching; word 0 is
    // the most significant word, and within a word the first byte is on top.
    function automatic logic [KEY_W-1:0] key_mask_f();
        logic [KEY_W-1:0] mask;
        int n;
        mask = '0;
        for (int w = 0; w < KEY_WORDS; w++) begin
            n = KEY_BYTES - 8 * w;
            if (n >= 8) begin
                mask[KEY_W-1-WORD_W*w -: WORD_W] = '1;
            end else if (n > 0) begin
                mask[KEY_W-1-WORD_W*w -: WORD_W] = {WORD_W{1'b1}} << (WORD_W - 8 * n);
            end
        end
        return mask;
    endfunction

    localparam logic [KEY_W-1:0] KEY_MASK = key_mask_f();

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [63:0]       key_word0;
        logic [63:0]       key_word1;
        logic [63:0]       key_word2;
        logic [63:0]       key_word3;
        logic [63:0]       payload_in;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [63:0]         payload_out;
        logic [SLOT_W-1:0]   slot;
        logic [ACTIVE_W-1:0] active_count;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } sta_state_t;

    typedef struct packed {
        logic load;
        logic tick;
        logic scan;
        logic take;
        logic miss;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic last;
        logic max_age_zero;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/sta_ram.sv =====
`default_nettype none

module sta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/sta_ctrl.sv =====
`default_nettype none
`include "session_table_with_aging_defines.svh"

module sta_ctrl import sta_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [FUNC_W-1:0] func,
    input  wire dp_status_t        st,
    output dp_cmd_t                cmd
);

    sta_state_t state_reg, state_next;
    logic       sweep_reg, sweep_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sweep_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    sweep_next = (func == FUNC_CLEANUP);
                    if (func inside {FUNC_ADD, FUNC_FIND, FUNC_REMOVE}) begin
                        state_next = ST_SCAN;
                    end else if (func == FUNC_CLEANUP && !st.max_age_zero) begin
                        state_next = ST_SCAN;
                    end else begin
                        cmd.tick   = (func == FUNC_TICK);
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (st.hit) begin
                    cmd.take = 1'b1;
                    if (!sweep_reg) begin
                        state_next = ST_FINISH;
                    end
                end
                if (st.last) begin
                    // A search that reaches the top slot without a hit has failed.
                    cmd.miss   = !sweep_reg && !st.hit;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `STA_ASSERT_NEXT(a_accept_leaves_idle, s_valid && s_ready, state_reg != ST_IDLE,
        "accepted transaction did not start an operation")
    `STA_ASSERT_NEXT(a_scan_ends, state_reg == ST_SCAN && st.last, state_reg == ST_FINISH,
        "scan continued past the last slot")

endmodule

`default_nettype wire

// ===== rtl/sta_dp.sv =====
`default_nettype none
`include "session_table_with_aging_defines.svh"

module sta_dp import sta_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire in_item_t    s_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       st,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

    // Latched operation.
    logic [FUNC_W-1:0]       func_reg, func_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_in_reg, pay_in_next;

    // Table control state.
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   live_reg, live_next;
    logic [TIME_W-1:0]  seconds_reg, seconds_next;
    logic [TIME_W-1:0]  max_age_reg, max_age_next;

    // Scan pipeline: issue a read, evaluate it in the next cycle.
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic             eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0] eval_idx_reg, eval_idx_next;

    // Result being built and the output register.
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [IDX_W-1:0]        res_slot_reg, res_slot_next;
    logic [PAYLOAD_BITS-1:0] res_pay_reg, res_pay_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    logic                    issue_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [KEY_W-1:0]        key_rd;
    logic [PAYLOAD_BITS-1:0] pay_rd;
    logic [TIME_W-1:0]       lu_rd;
    logic [TIME_W-1:0]       idle_time;
    logic                    entry_on;
    logic                    hit_cond;
    logic                    key_we, pay_we, lu_we;

    assign issue_en  = cmd.scan && (issue_cnt_reg < CNT_W'(ENTRIES));
    assign rd_addr   = issue_cnt_reg[IDX_W-1:0];
    assign idle_time = seconds_reg - lu_rd;
    assign entry_on  = valid_reg[eval_idx_reg];
    assign cfg_ready = 1'b1;

    sta_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (eval_idx_reg),
        .wdata (key_reg),
        .re    (issue_en),
        .raddr (rd_addr),
        .rdata (key_rd)
    );

    sta_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(ENTRIES)) u_pay_ram (
        .aclk  (aclk),
        .we    (pay_we),
        .waddr (eval_idx_reg),
        .wdata (pay_in_reg),
        .re    (issue_en),
        .raddr (rd_addr),
        .rdata (pay_rd)
    );

    sta_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_lu_ram (
        .aclk  (aclk),
        .we    (lu_we),
        .waddr (eval_idx_reg),
        .wdata (seconds_reg),
        .re    (issue_en),
        .raddr (rd_addr),
        .rdata (lu_rd)
    );

    always_comb begin
        case (func_reg)
            FUNC_ADD:     hit_cond = !entry_on;
            FUNC_FIND:    hit_cond = entry_on && (key_rd == key_reg);
            FUNC_REMOVE:  hit_cond = entry_on && (key_rd == key_reg);
            FUNC_CLEANUP: hit_cond = entry_on && (idle_time > max_age_reg);
            default:      hit_cond = 1'b0;
        endcase
    end

    assign st.hit          = eval_valid_reg && hit_cond;
    assign st.last         = eval_valid_reg && (eval_idx_reg == IDX_W'(ENTRIES - 1));
    assign st.max_age_zero = (max_age_reg == '0);
    assign st.out_free     = !m_valid_reg || m_ready;

    always_comb begin
        func_next       = func_reg;
        key_next        = key_reg;
        pay_in_next     = pay_in_reg;
        valid_next      = valid_reg;
        live_next       = live_reg;
        seconds_next    = seconds_reg;
        max_age_next    = max_age_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_pay_next    = res_pay_reg;
        key_we          = 1'b0;
        pay_we          = 1'b0;
        lu_we           = 1'b0;
        issue_cnt_next  = issue_en ? issue_cnt_reg + CNT_W'(1) : issue_cnt_reg;
        eval_valid_next = issue_en;
        eval_idx_next   = rd_addr;

        if (cfg_valid) begin
            max_age_next = cfg_data;
        end

        if (cmd.load) begin
            func_next       = s_data.func;
            key_next        = {s_data.key_word0, s_data.key_word1,
                               s_data.key_word2, s_data.key_word3} & KEY_MASK;
            pay_in_next     = s_data.payload_in[PAYLOAD_BITS-1:0];
            res_status_next = STATUS_OK;
            res_slot_next   = '0;
            res_pay_next    = '0;
            issue_cnt_next  = '0;
        end

        if (cmd.tick) begin
            seconds_next = seconds_reg + TIME_W'(1);
        end

        if (cmd.take) begin
            case (func_reg)
                FUNC_ADD: begin
                    valid_next[eval_idx_reg] = 1'b1;
                    live_next                = live_reg + CNT_W'(1);
                    key_we                   = 1'b1;
                    pay_we                   = 1'b1;
                    lu_we                    = 1'b1;
                    res_slot_next            = eval_idx_reg;
                end
                FUNC_FIND: begin
                    lu_we         = 1'b1;
                    res_pay_next  = pay_rd;
                    res_slot_next = eval_idx_reg;
                end
                FUNC_REMOVE: begin
                    valid_next[eval_idx_reg] = 1'b0;
                    if (live_reg != '0) begin
                        live_next = live_reg - CNT_W'(1);
                    end
                    res_slot_next = eval_idx_reg;
                end
                FUNC_CLEANUP: begin
                    valid_next[eval_idx_reg] = 1'b0;
                    if (live_reg != '0) begin
                        live_next = live_reg - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.miss) begin
            res_status_next = (func_reg == FUNC_ADD) ? STATUS_FULL : STATUS_NOT_FOUND;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_data_next  = '{status:       res_status_reg,
                             payload_out:  64'(res_pay_reg),
                             slot:         SLOT_W'(res_slot_reg),
                             active_count: ACTIVE_W'(live_reg)};
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            live_reg       <= '0;
            seconds_reg    <= '0;
            max_age_reg    <= '0;
            issue_cnt_reg  <= '0;
            eval_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            live_reg       <= live_next;
            seconds_reg    <= seconds_next;
            max_age_reg    <= max_age_next;
            issue_cnt_reg  <= issue_cnt_next;
            eval_valid_reg <= eval_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        pay_in_reg     <= pay_in_next;
        eval_idx_reg   <= eval_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_pay_reg    <= res_pay_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `STA_ASSERT_NOW(a_live_matches_valid, 1'b1, $countones(valid_reg) == live_reg,
        "active count disagrees with the valid bits")
    `STA_ASSERT_NEXT(a_tick_advances, cmd.tick, seconds_reg == $past(seconds_reg) + 32'd1,
        "tick did not advance the seconds counter")
    `STA_ASSERT_NEXT(a_add_sets_valid, cmd.take && func_reg == FUNC_ADD,
        valid_reg[$past(eval_idx_reg)], "add did not mark its slot active")

endmodule

`default_nettype wire

// ===== rtl/session_table_with_aging.sv =====
// Tick, cleanup with max_age zero and unused codes finish without walking the slots; add, find,
// remove and cleanup with a nonzero max_age walk the slots. One transaction is handled at a time.
// A finished result waits in the output register while the next transaction is accepted.
// Reset (aresetn low, synchronous): all slots inactive, active count, seconds and max_age zero.
// Key, payload and last-used RAM contents are not cleared; only active slots are ever used.
`default_nettype none

module session_table_with_aging import sta_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Operation transactions.
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,

    // Result transactions, exactly one per operation.
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,

    // Write channel for the max_age register.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    // The controller sequences each operation: it accepts a transaction only when
    // idle, runs the slot walk for the operations that need one, and hands the
    // result to the output register once that register is free.
    //
    // The datapath holds the table. Valid bits and the active count are flip-flops;
    // key, payload and last-used time live in three small RAMs read at the same
    // slot each cycle of the walk. A read issued in one cycle is evaluated in the
    // next.
    //
    // Every search takes the lowest slot that qualifies: add looks for the lowest
    // inactive slot, find and remove for the lowest active slot with an equal key.
    // Cleanup with a nonzero max_age keeps walking and frees every active slot
    // whose idle time, taken modulo two to the thirty-second, exceeds max_age.

    dp_cmd_t    cmd;
    dp_status_t st;

    sta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .func    (s_data.func),
        .st      (st),
        .cmd     (cmd)
    );

    sta_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== bench/tb_session_table_with_aging.sv =====
`default_nettype none

module tb_session_table_with_aging;
    import sta_pkg::*;

    // The run is bounded by a cycle count far beyond the slowest correct run: about
    // 1800 operations, each with at worst a slot walk, a sender gap and a receiver
    // stall, plus one long receiver hold-off.
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int          POOL_SIZE   = 20;
    // The block stores and matches only the leading KEY_BYTES bytes of the key, and only
    // the low PAYLOAD_BITS bits of the payload.
    localparam logic [KEY_W-1:0] STORED_KEY_BITS = {KEY_W{1'b1}} << (KEY_W - 8 * KEY_BYTES);
    localparam logic [63:0]      STORED_PAY_BITS = {64{1'b1}} >> (64 - PAYLOAD_BITS);

    logic            aclk      = 1'b0;
    logic            aresetn   = 1'b0;
    logic            s_valid   = 1'b0;
    in_item_t        s_data    = '0;
    logic            m_ready   = 1'b0;
    logic            cfg_valid = 1'b0;
    logic [31:0]     cfg_data  = '0;
    wire logic       s_ready;
    wire logic       m_valid;
    wire logic       cfg_ready;
    out_item_t       m_data;

    session_table_with_aging u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Session table predictor. This is the testbench's own copy of the table
    // state, updated once per accepted operation transaction.
    // ------------------------------------------------------------------------
    logic              tbl_used [ENTRIES];
    logic [KEY_W-1:0]  tbl_key  [ENTRIES];
    logic [63:0]       tbl_pay  [ENTRIES];
    logic [31:0]       tbl_seen [ENTRIES];
    int unsigned       live_cnt  = 0;
    logic [31:0]       sec_now   = '0;
    logic [31:0]       age_limit = '0;
    int unsigned       aged_out  = 0;

    initial begin
        for (int e = 0; e < ENTRIES; e++) begin
            tbl_used[e] = 1'b0;
        end
    end

    // Applies one operation to the predicted table and returns the result the
    // block must produce for it. Every search takes the lowest qualifying slot.
    function automatic out_item_t apply_session_op(in_item_t op);
        out_item_t        r;
        logic [KEY_W-1:0] k;
        logic [31:0]      idle;
        int               hit;
        r = '0;
        hit = -1;
        k = {op.key_word0, op.key_word1, op.key_word2, op.key_word3} & STORED_KEY_BITS;
        case (op.func)
            FUNC_ADD: begin
                // Duplicate keys are not checked; a second entry is simply created.
                if (live_cnt < ENTRIES) begin
                    for (int e = 0; e < ENTRIES; e++) begin
                        if (!tbl_used[e]) begin
                            hit = e;
                            break;
                        end
                    end
                end
                if (hit < 0) begin
                    r.status = STATUS_FULL;
                end else begin
                    tbl_used[hit] = 1'b1;
                    tbl_key[hit]  = k;
                    tbl_pay[hit]  = op.payload_in & STORED_PAY_BITS;
                    tbl_seen[hit] = sec_now;
                    live_cnt++;
                    r.slot = hit[SLOT_W-1:0];
                end
            end
            FUNC_FIND, FUNC_REMOVE: begin
                for (int e = 0; e < ENTRIES; e++) begin
                    if (tbl_used[e] && tbl_key[e] == k) begin
                        hit = e;
                        break;
                    end
                end
                if (hit < 0) begin
                    r.status = STATUS_NOT_FOUND;
                end else if (op.func == FUNC_FIND) begin
                    // A hit refreshes the entry's last-used time.
                    tbl_seen[hit] = sec_now;
                    r.payload_out = tbl_pay[hit];
                    r.slot = hit[SLOT_W-1:0];
                end else begin
                    tbl_used[hit] = 1'b0;
                    live_cnt--;
                    r.slot = hit[SLOT_W-1:0];
                end
            end
            FUNC_CLEANUP: begin
                // A zero max_age turns cleanup into a no-op. Idle time wraps modulo 2^32.
                if (age_limit != 0) begin
                    for (int e = 0; e < ENTRIES; e++) begin
                        idle = sec_now - tbl_seen[e];
                        if (tbl_used[e] && idle > age_limit) begin
                            tbl_used[e] = 1'b0;
                            live_cnt--;
                            aged_out++;
                        end
                    end
                end
            end
            FUNC_TICK: begin
                sec_now = sec_now + 32'd1;
            end
            default: begin
                // Unused function codes change nothing.
            end
        endcase
        r.active_count = live_cnt[ACTIVE_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Shared bookkeeping between the stimulus, driver and monitor processes.
    // ------------------------------------------------------------------------
    in_item_t    op_queue [$];          // operations waiting to be offered
    out_item_t   pending_results [$];   // predicted results, oldest first
    logic        op_taken     = 1'b0;   // set when the offered operation is accepted
    logic        quiet_tail   = 1'b0;   // no idling on either side in the last phase
    int unsigned ops_taken    = 0;
    int unsigned results_seen = 0;
    int unsigned full_seen    = 0;
    int unsigned missed_seen  = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    function automatic void report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch in %s at result %0d: expected %h, got %h",
                     what, results_seen, want, got);
        end
    endfunction

    // Idling is suspended in the last phase and in regular calm windows, so that
    // stretches of back-to-back transactions occur as well.
    function automatic logic calm_now();
        return quiet_tail || ((ops_taken / 80) % 4 == 3);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: samples every handshake at the rising edge. A result is checked
    // against the oldest prediction before the operation accepted at the same
    // edge adds its own prediction, since results always trail their operation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        out_item_t want;
        out_item_t predicted;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no operation pending", '0, m_data.payload_out);
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", want.status, m_data.status);
                    if (m_data.payload_out !== want.payload_out)
                        report_mismatch("payload_out", want.payload_out, m_data.payload_out);
                    if (m_data.slot !== want.slot)
                        report_mismatch("slot", want.slot, m_data.slot);
                    if (m_data.active_count !== want.active_count)
                        report_mismatch("active_count", want.active_count, m_data.active_count);
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                predicted = apply_session_op(s_data);
                pending_results.push_back(predicted);
                if (predicted.status == STATUS_FULL) full_seen++;
                if (predicted.status == STATUS_NOT_FOUND) missed_seen++;
                ops_taken++;
                op_taken = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                age_limit = cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: updates the operation channel at the falling edge. An offered
    // transaction is held unchanged until the monitor has seen it accepted.
    // After each offer the sender may go quiet for a random burst.
    // ------------------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(negedge aclk) begin : driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !op_taken) begin
            // Still waiting for the current transaction to be taken.
        end else begin
            op_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (op_queue.size() > 0) begin
                s_data  <= op_queue.pop_front();
                s_valid <= 1'b1;
                if (!calm_now() && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(1, 14);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off early in the run
    // while the sender keeps offering. The block then holds a finished result,
    // takes one more operation, and has to stall its input.
    // ------------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    logic        held_once  = 1'b0;

    always @(negedge aclk) begin : receiver
        if (!held_once && ops_taken >= 150) begin
            held_once = 1'b1;
            hold_left = 400;
        end
        if (stall_left == 0 && !calm_now() && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14);
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < KEY_W / 32; i++) begin
            k = (k << 32) | KEY_W'($urandom);
        end
        return k;
    endfunction

    function automatic in_item_t make_op(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                         logic [63:0] pay);
        in_item_t op;
        op.func       = f;
        op.key_word0  = k[KEY_W-1 -: 64];
        op.key_word1  = k[KEY_W-65 -: 64];
        op.key_word2  = k[KEY_W-129 -: 64];
        op.key_word3  = k[63:0];
        op.payload_in = pay;
        return op;
    endfunction

    // Mostly keys from a small pool so that finds and removes hit live sessions;
    // some near misses that differ in one bit, and some keys never seen before.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] flip;
        int unsigned      r;
        r = $urandom_range(0, 9);
        k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r == 8) begin
            flip = '0;
            flip[$urandom_range(0, KEY_W - 1)] = 1'b1;
            k = k ^ flip;
        end else if (r == 9) begin
            k = random_key();
        end
        return k;
    endfunction

    // Queues n random operations; the weights are percentages, and whatever
    // is left over goes to the unused function codes.
    task automatic queue_random_ops(int n, int unsigned w_add, int unsigned w_find,
                                    int unsigned w_rm, int unsigned w_tick,
                                    int unsigned w_clean);
        logic [FUNC_W-1:0] f;
        int unsigned       r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < w_add)                                  f = FUNC_ADD;
            else if (r < w_add + w_find)                    f = FUNC_FIND;
            else if (r < w_add + w_find + w_rm)             f = FUNC_REMOVE;
            else if (r < w_add + w_find + w_rm + w_tick)    f = FUNC_TICK;
            else if (r < w_add + w_find + w_rm + w_tick + w_clean) f = FUNC_CLEANUP;
            else                                            f = FUNC_W'($urandom_range(5, 7));
            op_queue.push_back(make_op(f, pick_key(), {$urandom, $urandom}));
        end
    endtask

    // Waits until every queued operation is accepted and every predicted result
    // has arrived, then lets the block settle past its longest latency.
    task automatic wait_until_idle();
        while (op_queue.size() != 0 || s_valid || pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (25) @(posedge aclk);
    endtask

    task automatic write_max_age(logic [31:0] value);
        @(negedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence: a directed opening with max_age at its reset value of
    // zero, then random phases under several max_age settings.
    // ------------------------------------------------------------------------
    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = random_key();
        end

        // Directed transactions: empty-table lookups, extreme keys and payloads,
        // duplicate keys, a near miss, filling the table and adding to a full one.
        op_queue.push_back(make_op(FUNC_CLEANUP, '0, '0));
        op_queue.push_back(make_op(FUNC_FIND, key_pool[1], '0));
        op_queue.push_back(make_op(FUNC_REMOVE, key_pool[0], '0));
        op_queue.push_back(make_op(FUNC_ADD, key_pool[0], '0));
        op_queue.push_back(make_op(FUNC_ADD, key_pool[1], '1));
        op_queue.push_back(make_op(FUNC_ADD, key_pool[1], 64'h0123_4567_89AB_CDEF));
        op_queue.push_back(make_op(FUNC_FIND, key_pool[1], '0));
        op_queue.push_back(make_op(FUNC_REMOVE, key_pool[1], '0));
        op_queue.push_back(make_op(FUNC_FIND, key_pool[1], '1));
        op_queue.push_back(make_op(FUNC_FIND, key_pool[1] ^ KEY_W'(1), '0));
        for (int i = 2; i < ENTRIES; i++) begin
            op_queue.push_back(make_op(FUNC_ADD, key_pool[i], {$urandom, $urandom}));
        end
        op_queue.push_back(make_op(FUNC_ADD, key_pool[16], '1));
        op_queue.push_back(make_op(FUNC_TICK, '1, '1));
        op_queue.push_back(make_op(FUNC_W'(5), '1, '1));
        op_queue.push_back(make_op(FUNC_W'(7), '0, '0));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait_until_idle();

        // All-ones max_age: nothing can ever age out.
        write_max_age(32'hFFFF_FFFF);
        queue_random_ops(300, 30, 25, 20, 15, 8);
        wait_until_idle();

        // The smallest nonzero age: cleanup frees anything idle for two seconds.
        write_max_age(32'd1);
        queue_random_ops(300, 30, 20, 10, 25, 13);
        wait_until_idle();

        write_max_age(32'd7);
        queue_random_ops(300, 35, 25, 10, 20, 8);
        wait_until_idle();

        write_max_age(32'h8000_0000);
        queue_random_ops(200, 25, 25, 25, 15, 8);
        wait_until_idle();

        // Cleanup disabled again by an explicit zero.
        write_max_age(32'd0);
        queue_random_ops(200, 30, 25, 20, 15, 8);
        wait_until_idle();

        // Final phase runs back to back with no idling on either side.
        write_max_age(32'd12);
        quiet_tail = 1'b1;
        queue_random_ops(500, 30, 25, 12, 22, 9);
        wait_until_idle();

        $display("Ran %0d operations and checked %0d results under seven max_age settings.",
                 ops_taken, results_seen);
        $display("Adds to a full table: %0d, lookups that missed: %0d, sessions aged out: %0d.",
                 full_seen, missed_seen, aged_out);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
